/* rtl/vfc_pkg.sv */
// ----------------------------------------------------------------------------
// vfc_pkg
// Shared types, codes and constants for the voxel face culling block.
// ----------------------------------------------------------------------------
package vfc_pkg;

    // Default chunk geometry and stored type width.
    localparam int VFC_SIZE_X    = 16;
    localparam int VFC_SIZE_Y    = 256;
    localparam int VFC_SIZE_Z    = 16;
    localparam int VFC_TYPE_BITS = 8;

    // Field widths fixed by the stream format.
    localparam int VCOUNT_W = 21;
    localparam int S_DATA_W = 32;
    localparam int S_USER_W = 2;
    localparam int M_DATA_W = 56;

    // Request codes carried on s_tuser.
    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_MESH  = 2'd1;
    localparam logic [1:0] REQ_BEGIN = 2'd2;

    // Face directions in visiting order.
    localparam logic [2:0] DIR_PX    = 3'd0;
    localparam logic [2:0] DIR_NX    = 3'd1;
    localparam logic [2:0] DIR_PY    = 3'd2;
    localparam logic [2:0] DIR_NY    = 3'd3;
    localparam logic [2:0] DIR_PZ    = 3'd4;
    localparam logic [2:0] DIR_NZ    = 3'd5;
    localparam logic [2:0] DIR_COUNT = 3'd6;

    // Q0.8 shading: top is 1.0 saturated, bottom 0.4, sides 0.7.
    localparam logic [7:0] LIGHT_TOP    = 8'd255;
    localparam logic [7:0] LIGHT_BOTTOM = 8'd102;
    localparam logic [7:0] LIGHT_SIDE   = 8'd179;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       latch_item;
        logic       mem_write;
        logic       clr_vcount;
        logic       rd_center;
        logic       take_center;
        logic       rd_nbr;
        logic [2:0] dir;
        logic       check;
        logic       load_face;
    } vfc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] req;
        logic       in_range;
        logic       solid;
        logic       mask_empty;
        logic       out_free;
    } vfc_status_t;

    // Shade for one face direction.
    function automatic logic [7:0] face_light(input logic [2:0] dir);
        logic [7:0] lvl;
        case (dir)
            DIR_PY:  lvl = LIGHT_TOP;
            DIR_NY:  lvl = LIGHT_BOTTOM;
            default: lvl = LIGHT_SIDE;
        endcase
        return lvl;
    endfunction

endpackage

/* rtl/vfc_ctrl.sv */
// ----------------------------------------------------------------------------
// vfc_ctrl
// Sequencer for one item at a time: dispatch, center read, six neighbor
// reads through the single store port, then face emission.
// ----------------------------------------------------------------------------
module vfc_ctrl
    import vfc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  vfc_status_t status,
    output vfc_cmd_t    cmd
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DISPATCH = 3'd1;
    localparam logic [2:0] S_CENTER   = 3'd2;
    localparam logic [2:0] S_NBR      = 3'd3;
    localparam logic [2:0] S_EMIT     = 3'd4;

    logic [2:0] state_reg, state_next;
    logic [2:0] dir_reg, dir_next;

    // State and neighbor counter registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            dir_reg   <= DIR_PX;
        end
        else
        begin
            state_reg <= state_next;
            dir_reg   <= dir_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        dir_next   = dir_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.latch_item = 1'b1;
                    state_next     = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                state_next = S_IDLE;
                case (status.req)
                    REQ_WRITE: cmd.mem_write  = 1'b1;
                    REQ_BEGIN: cmd.clr_vcount = 1'b1;
                    REQ_MESH:
                    begin
                        if (status.in_range)
                        begin
                            cmd.rd_center = 1'b1;
                            state_next    = S_CENTER;
                        end
                    end
                    default: state_next = S_IDLE;
                endcase
            end
            S_CENTER:
            begin
                cmd.take_center = 1'b1;
                if (status.solid)
                begin
                    cmd.rd_nbr = 1'b1;
                    cmd.dir    = DIR_PX;
                    dir_next   = DIR_NX;
                    state_next = S_NBR;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_NBR:
            begin
                // Each cycle checks the neighbor read last cycle and issues the next.
                cmd.check = 1'b1;
                if (dir_reg == DIR_COUNT)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    cmd.rd_nbr = 1'b1;
                    cmd.dir    = dir_reg;
                    dir_next   = dir_reg + 3'd1;
                end
            end
            S_EMIT:
            begin
                if (status.mask_empty)
                begin
                    state_next = S_IDLE;
                end
                else if (status.out_free)
                begin
                    cmd.load_face = 1'b1;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

/* rtl/vfc_datapath.sv */
// ----------------------------------------------------------------------------
// vfc_datapath
// Item registers, chunk store, neighbor mask, vertex counter and the
// output register for face records.
// ----------------------------------------------------------------------------
module vfc_datapath
    import vfc_pkg::*;
#(
    parameter int SIZE_X    = VFC_SIZE_X,
    parameter int SIZE_Y    = VFC_SIZE_Y,
    parameter int SIZE_Z    = VFC_SIZE_Z,
    parameter int TYPE_BITS = VFC_TYPE_BITS
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_wdata,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic [S_USER_W-1:0] s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,
    output logic                m_tlast,
    input  vfc_cmd_t            cmd,
    output vfc_status_t         status
);

    localparam int VOXELS = SIZE_X * SIZE_Y * SIZE_Z;
    localparam int AW     = (VOXELS > 1) ? $clog2(VOXELS) : 1;
    localparam int WW     = TYPE_BITS + 2;

    // Item registers.
    logic [1:0]          req_reg;
    logic [3:0]          x_reg;
    logic [7:0]          y_reg;
    logic [3:0]          z_reg;
    logic [7:0]          kind_reg;
    logic                solid_reg;
    logic                clear_reg;

    logic                edge_reg;
    logic [5:0]          mask_reg;
    logic [VCOUNT_W-1:0] vcount_reg;
    logic [TYPE_BITS-1:0] ckind_reg;

    logic [WW-1:0]       mem [VOXELS];
    logic [WW-1:0]       rdata_reg;
    logic [2:0]          chk_dir_reg;
    logic                chk_out_reg;

    logic                out_valid_reg;
    logic [M_DATA_W-1:0] out_data_reg;
    logic                out_last_reg;

    logic                item_inside;
    logic [4:0]          nx;
    logic [8:0]          ny;
    logic [4:0]          nz;
    logic                under;
    logic                nbr_out;
    logic [AW-1:0]       center_addr;
    logic [AW-1:0]       nbr_addr;
    logic [AW-1:0]       mem_addr;
    logic                mem_we;
    logic                mem_re;
    logic [15:0]         kind16;
    logic [15:0]         ckind16;
    logic [WW-1:0]       wword;
    logic [2:0]          pick_dir;
    logic [5:0]          pick_bit;
    logic [5:0]          rest_mask;
    logic                out_free;

    // Linear cell index: x fastest, then z, then y.
    function automatic logic [AW-1:0] cell_addr(input logic [4:0] cx,
                                                 input logic [8:0] cy,
                                                 input logic [4:0] cz);
        return AW'((int'(cy) * SIZE_Z + int'(cz)) * SIZE_X + int'(cx));
    endfunction

    function automatic logic in_chunk(input logic [4:0] cx,
                                      input logic [8:0] cy,
                                      input logic [4:0] cz);
        return (int'(cx) < SIZE_X) && (int'(cy) < SIZE_Y) && (int'(cz) < SIZE_Z);
    endfunction

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            edge_reg <= 1'b1;
        else if (cfg_we)
            edge_reg <= cfg_wdata;
    end

    // Capture the accepted item.
    always_ff @(posedge clk)
    begin
        if (cmd.latch_item)
        begin
            req_reg   <= s_tuser;
            x_reg     <= s_tdata[3:0];
            y_reg     <= s_tdata[11:4];
            z_reg     <= s_tdata[15:12];
            kind_reg  <= s_tdata[23:16];
            solid_reg <= s_tdata[24];
            clear_reg <= s_tdata[25];
        end
    end

    // Neighbor coordinates for the direction being issued.
    always_comb
    begin
        nx    = {1'b0, x_reg};
        ny    = {1'b0, y_reg};
        nz    = {1'b0, z_reg};
        under = 1'b0;
        case (cmd.dir)
            DIR_PX: nx = nx + 5'd1;
            DIR_NX:
            begin
                under = (x_reg == 4'd0);
                nx    = nx - 5'd1;
            end
            DIR_PY: ny = ny + 9'd1;
            DIR_NY:
            begin
                under = (y_reg == 8'd0);
                ny    = ny - 9'd1;
            end
            DIR_PZ: nz = nz + 5'd1;
            DIR_NZ:
            begin
                under = (z_reg == 4'd0);
                nz    = nz - 5'd1;
            end
            default: under = 1'b0;
        endcase
    end

    assign item_inside = in_chunk({1'b0, x_reg}, {1'b0, y_reg}, {1'b0, z_reg});
    assign nbr_out     = under || !in_chunk(nx, ny, nz);
    assign center_addr = cell_addr({1'b0, x_reg}, {1'b0, y_reg}, {1'b0, z_reg});
    assign nbr_addr    = cell_addr(nx, ny, nz);
    assign mem_addr    = cmd.rd_nbr ? nbr_addr : center_addr;
    assign mem_we      = cmd.mem_write && item_inside;
    assign mem_re      = cmd.rd_center || (cmd.rd_nbr && !nbr_out);

    // Stored word: type in the low bits, solid above, transparent on top.
    assign kind16 = {8'h00, kind_reg};
    assign wword  = {clear_reg, solid_reg, kind16[TYPE_BITS-1:0]};

    // Single-port chunk store with registered read data.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= wword;
        if (mem_re)
            rdata_reg <= mem[mem_addr];
    end

    // Remember which neighbor the pending read belongs to.
    always_ff @(posedge clk)
    begin
        if (cmd.rd_nbr)
        begin
            chk_dir_reg <= cmd.dir;
            chk_out_reg <= nbr_out;
        end
        if (cmd.take_center)
            ckind_reg <= rdata_reg[TYPE_BITS-1:0];
    end

    // Lowest pending face direction.
    always_comb
    begin
        pick_dir = DIR_PX;
        pick_bit = '0;
        for (int i = 5; i >= 0; i--)
        begin
            if (mask_reg[i])
            begin
                pick_dir = 3'(i);
                pick_bit = 6'(1) << i;
            end
        end
    end

    assign rest_mask = mask_reg & ~pick_bit;

    // Face mask: cleared on a new center, filled by checks, drained by loads.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mask_reg <= '0;
        else if (cmd.take_center)
            mask_reg <= '0;
        else if (cmd.check)
            mask_reg[chk_dir_reg] <= chk_out_reg ? edge_reg : rdata_reg[TYPE_BITS+1];
        else if (cmd.load_face)
            mask_reg <= rest_mask;
    end

    // Running base vertex index, four vertices per face.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vcount_reg <= '0;
        else if (cmd.clr_vcount)
            vcount_reg <= '0;
        else if (cmd.load_face)
            vcount_reg <= vcount_reg + VCOUNT_W'(4);
    end

    assign out_free = !out_valid_reg || m_tready;
    assign ckind16  = 16'(ckind_reg);

    // Output register for face records.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_face)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_face)
        begin
            out_data_reg <= {vcount_reg, face_light(pick_dir), ckind16[7:0],
                             z_reg, y_reg, x_reg, pick_dir};
            out_last_reg <= (rest_mask == 6'd0);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    assign status.req        = req_reg;
    assign status.in_range   = item_inside;
    assign status.solid      = rdata_reg[TYPE_BITS];
    assign status.mask_empty = (mask_reg == 6'd0);
    assign status.out_free   = out_free;

endmodule

/* rtl/voxel_face_culling.sv */
// ----------------------------------------------------------------------------
// voxel_face_culling
// Voxel chunk store that answers mesh requests with culled face records.
//
//   Channel  Direction  Handshake          Payload
//   s_*      in         tvalid/tready      tdata block fields, tuser request
//   m_*      out        tvalid/tready      tdata face record, tlast last face
//   cfg_*    in         write enable only  edge_is_transparent
//
// A write or begin item is dispatched and done. A mesh item reads the center
// first and ends there when the block is not solid, else reads the six neighbors
// through the single store port, then emits one face per cycle while the output is free.
// Faces leave through an output register; a stall on m_tready holds emission.
// Reset clears the vertex counter and sets edge_is_transparent to 1; the
// store contents are undefined until written.
// ----------------------------------------------------------------------------
module voxel_face_culling
    import vfc_pkg::*;
#(
    parameter int SIZE_X    = VFC_SIZE_X,
    parameter int SIZE_Y    = VFC_SIZE_Y,
    parameter int SIZE_Z    = VFC_SIZE_Z,
    parameter int TYPE_BITS = VFC_TYPE_BITS
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_wdata,
    input  logic                s_tvalid,
    output logic                s_tready,
    // pos_x[3:0], pos_y[11:4], pos_z[15:12], block_kind[23:16],
    // is_solid[24], is_clear[25], zero fill[31:26]
    input  logic [S_DATA_W-1:0] s_tdata,
    // req_type[1:0]
    input  logic [S_USER_W-1:0] s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // face_dir[2:0], face_x[6:3], face_y[14:7], face_z[18:15],
    // face_kind[26:19], light_level[34:27], base_vertex[55:35]
    output logic [M_DATA_W-1:0] m_tdata,
    output logic                m_tlast
);

    vfc_cmd_t    cmd;
    vfc_status_t status;

    vfc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    vfc_datapath #(
        .SIZE_X    (SIZE_X),
        .SIZE_Y    (SIZE_Y),
        .SIZE_Z    (SIZE_Z),
        .TYPE_BITS (TYPE_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .status    (status)
    );

    // A face that is not the last is followed at once by the next one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
        else $error("face run broken before its last face");

    // No face is pending while a new item can be taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> status.mask_empty)
        else $error("pending faces left behind at accept");

    // Faces are only loaded once the accepting side is closed.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_face |-> (!s_tready && !cmd.check && !cmd.rd_nbr))
        else $error("face loaded outside emission");

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the voxel face culling block. Voxel writes, begin
// and mesh requests go in on the slave stream, and every face record on the
// master stream is compared against a predicted copy of the chunk store and
// vertex counter. Both streams idle in random bursts, and the edge
// transparency register is switched between test phases while the block is
// idle.
// ----------------------------------------------------------------------------
module testbench;
    import vfc_pkg::*;

    // Request code that the block ignores.
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 32;
    localparam int PHASE_ITEMS   = 75;
    localparam int CALM_ITEMS    = 60;
    localparam int CLUSTER_ITEMS = 20;

    // One predicted face record.
    typedef struct {
        logic [2:0]          dir;
        logic [3:0]          x;
        logic [7:0]          y;
        logic [3:0]          z;
        logic [7:0]          kind;
        logic [7:0]          light;
        logic [VCOUNT_W-1:0] base;
        logic                last;
    } face_rec_t;

    // Face predictor and record checker.
    class face_scoreboard;
        bit [VFC_TYPE_BITS+1:0] voxel_word [65536];
        bit                     voxel_known [65536];
        logic [VCOUNT_W-1:0]    vertex_count;
        logic                   edge_clear;
        face_rec_t              expected_faces [$];
        int                     errors;

        function new();
            vertex_count = '0;
            edge_clear   = 1'b1;
            errors       = 0;
        endfunction

        function void set_edge(logic value);
            edge_clear = value;
        endfunction

        function bit in_chunk(int x, int y, int z);
            return x >= 0 && x < VFC_SIZE_X && y >= 0 && y < VFC_SIZE_Y &&
                   z >= 0 && z < VFC_SIZE_Z;
        endfunction

        function int cell_index(int x, int y, int z);
            return (y * VFC_SIZE_Z + z) * VFC_SIZE_X + x;
        endfunction

        function int pending();
            return expected_faces.size();
        endfunction

        // Update the predicted state for one accepted request transfer.
        function void note_input(logic [1:0] req, logic [S_DATA_W-1:0] data);
            int                     x;
            int                     y;
            int                     z;
            int                     nx;
            int                     ny;
            int                     nz;
            int                     count;
            int                     i;
            logic [2:0]             dir;
            logic                   nbr_clear;
            bit [VFC_TYPE_BITS+1:0] word;
            face_rec_t              faces [6];

            x = int'(data[3:0]);
            y = int'(data[11:4]);
            z = int'(data[15:12]);
            case (req)
                REQ_WRITE:
                begin
                    // Type, solid and clear flags sit in the same order as the stored word.
                    voxel_word[cell_index(x, y, z)]  = data[25:16];
                    voxel_known[cell_index(x, y, z)] = 1'b1;
                end
                REQ_BEGIN:
                begin
                    vertex_count = '0;
                end
                REQ_MESH:
                begin
                    word  = voxel_word[cell_index(x, y, z)];
                    count = 0;
                    if (word[VFC_TYPE_BITS])
                    begin
                        for (i = 0; i < 6; i++)
                        begin
                            dir = i[2:0];
                            nx  = x;
                            ny  = y;
                            nz  = z;
                            faces[count].light = LIGHT_SIDE;
                            case (dir)
                                DIR_PX: nx = x + 1;
                                DIR_NX: nx = x - 1;
                                DIR_PY:
                                begin
                                    ny = y + 1;
                                    faces[count].light = LIGHT_TOP;
                                end
                                DIR_NY:
                                begin
                                    ny = y - 1;
                                    faces[count].light = LIGHT_BOTTOM;
                                end
                                DIR_PZ: nz = z + 1;
                                default: nz = z - 1;
                            endcase
                            if (in_chunk(nx, ny, nz))
                                nbr_clear = voxel_word[cell_index(nx, ny, nz)][VFC_TYPE_BITS+1];
                            else
                                nbr_clear = edge_clear;
                            if (nbr_clear)
                            begin
                                faces[count].dir  = dir;
                                faces[count].x    = x[3:0];
                                faces[count].y    = y[7:0];
                                faces[count].z    = z[3:0];
                                faces[count].kind = word[7:0];
                                faces[count].base = vertex_count;
                                faces[count].last = 1'b0;
                                vertex_count      = vertex_count + VCOUNT_W'(4);
                                count++;
                            end
                        end
                    end
                    for (i = 0; i < count; i++)
                    begin
                        faces[i].last  = (i == count - 1);
                        expected_faces = {expected_faces, faces[i]};
                    end
                end
                default:
                begin
                end
            endcase
        endfunction

        task report_mismatch(string msg);
            $display("ERROR: %s", msg);
            errors++;
        endtask

        task check_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
        endtask

        // Compare one face record transfer against the oldest prediction.
        task check_face(logic [M_DATA_W-1:0] data, logic last);
            face_rec_t want;

            if (expected_faces.size() == 0)
            begin
                report_mismatch($sformatf("face record %h arrived with none expected", data));
                return;
            end
            want = expected_faces.pop_front();
            check_field("face_dir", 32'(data[2:0]), 32'(want.dir));
            check_field("face_x", 32'(data[6:3]), 32'(want.x));
            check_field("face_y", 32'(data[14:7]), 32'(want.y));
            check_field("face_z", 32'(data[18:15]), 32'(want.z));
            check_field("face_kind", 32'(data[26:19]), 32'(want.kind));
            check_field("light_level", 32'(data[34:27]), 32'(want.light));
            check_field("base_vertex", 32'(data[55:35]), 32'(want.base));
            check_field("last_face", 32'(last), 32'(want.last));
        endtask
    endclass

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cfg_we;
    logic                cfg_wdata;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic [S_USER_W-1:0] s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tlast;

    int             cycles      = 0;
    int             items_sent  = 0;
    bit             send_gaps   = 1'b1;
    bit             recv_stalls = 1'b1;
    face_scoreboard sb;

    voxel_face_culling u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // Free-running clock.
    always #5 clk = ~clk;

    // Watchdog on the overall run length.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Check every face record transfer.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_face(m_tdata, m_tlast);
    end

    // Receiver with random stall bursts.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (recv_stalls && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
                m_tready <= 1'b1;
            end
        end
    end

    function automatic logic [S_DATA_W-1:0] pack_item(int x, int y, int z, logic [7:0] kind,
                                                      logic solid, logic clear);
        return {6'b0, clear, solid, kind, z[3:0], y[7:0], x[3:0]};
    endfunction

    function automatic logic [S_DATA_W-1:0] random_payload(int x, int y, int z);
        return pack_item(x, y, z, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)));
    endfunction

    function automatic int pick_origin(int span);
        int choice;

        choice = $urandom_range(0, 3);
        if (choice == 0)
            return 0;
        else if (choice == 1)
            return span - 3;
        return $urandom_range(0, span - 3);
    endfunction

    // Drive one request and hold it until the transfer completes. Valid is
    // left high so a following request can go out back to back.
    task automatic send_item(logic [1:0] req, logic [S_DATA_W-1:0] data);
        if (send_gaps && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= req;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.note_input(req, data);
        if (req != REQ_UNUSED)
            items_sent++;
    endtask

    task automatic write_voxel(int x, int y, int z, logic [7:0] kind, logic solid,
                               logic clear);
        send_item(REQ_WRITE, pack_item(x, y, z, kind, solid, clear));
    endtask

    // Store a random voxel where the chunk has never been written.
    task automatic fill_if_unknown(int x, int y, int z);
        if (sb.in_chunk(x, y, z) && !sb.voxel_known[sb.cell_index(x, y, z)])
            send_item(REQ_WRITE, random_payload(x, y, z));
    endtask

    // Mesh one voxel after making sure it and its neighbors hold data.
    task automatic mesh_voxel(int x, int y, int z);
        fill_if_unknown(x, y, z);
        fill_if_unknown(x + 1, y, z);
        fill_if_unknown(x - 1, y, z);
        fill_if_unknown(x, y + 1, z);
        fill_if_unknown(x, y - 1, z);
        fill_if_unknown(x, y, z + 1);
        fill_if_unknown(x, y, z - 1);
        send_item(REQ_MESH, random_payload(x, y, z));
    endtask

    // Drop valid and wait until every predicted face has been seen.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_edge(logic value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_edge(value);
    endtask

    // Random traffic around small clusters of voxels, so most meshes see
    // written neighbors and some touch the chunk boundary.
    task automatic run_random(int count, bit calm_tail);
        int origin_x;
        int origin_y;
        int origin_z;
        int x;
        int y;
        int z;
        int pick;
        int start;
        int cluster_left;

        start        = items_sent;
        cluster_left = 0;
        origin_x     = 0;
        origin_y     = 0;
        origin_z     = 0;
        while (items_sent - start < count)
        begin
            if (cluster_left == 0)
            begin
                origin_x     = pick_origin(VFC_SIZE_X);
                origin_y     = pick_origin(VFC_SIZE_Y);
                origin_z     = pick_origin(VFC_SIZE_Z);
                cluster_left = CLUSTER_ITEMS;
                send_gaps    = $urandom_range(0, 3) != 0;
                recv_stalls  = $urandom_range(0, 3) != 0;
            end
            if (calm_tail && items_sent - start >= count - CALM_ITEMS)
            begin
                send_gaps   = 1'b0;
                recv_stalls = 1'b0;
            end
            x    = origin_x + $urandom_range(0, 2);
            y    = origin_y + $urandom_range(0, 2);
            z    = origin_z + $urandom_range(0, 2);
            pick = $urandom_range(0, 99);
            if (pick < 35)
                write_voxel(x, y, z, 8'($urandom_range(0, 255)), $urandom_range(0, 9) < 7,
                            1'($urandom_range(0, 1)));
            else if (pick < 80)
                mesh_voxel(x, y, z);
            else if (pick < 88)
                send_item(REQ_BEGIN, random_payload($urandom_range(0, 15),
                          $urandom_range(0, 255), $urandom_range(0, 15)));
            else if (pick < 93)
                send_item(REQ_UNUSED, random_payload($urandom_range(0, 15),
                          $urandom_range(0, 255), $urandom_range(0, 15)));
            else
                send_item(REQ_WRITE, random_payload($urandom_range(0, 15),
                          $urandom_range(0, 255), $urandom_range(0, 15)));
            cluster_left--;
        end
    endtask

    // Main sequence.
    initial
    begin
        sb = new();
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_wdata <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= REQ_WRITE;
        m_tready  <= 1'b1;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Low corner with the reset edge setting: every face is visible.
        write_voxel(0, 0, 0, 8'hFF, 1'b1, 1'b0);
        write_voxel(1, 0, 0, 8'h00, 1'b0, 1'b1);
        write_voxel(0, 1, 0, 8'h55, 1'b0, 1'b1);
        write_voxel(0, 0, 1, 8'hAA, 1'b1, 1'b1);
        mesh_voxel(0, 0, 0);

        // High corner with one opaque neighbor.
        write_voxel(15, 255, 15, 8'h00, 1'b1, 1'b1);
        write_voxel(14, 255, 15, 8'h80, 1'b1, 1'b0);
        write_voxel(15, 254, 15, 8'h7F, 1'b0, 1'b1);
        write_voxel(15, 255, 14, 8'h01, 1'b0, 1'b1);
        mesh_voxel(15, 255, 15);

        // Counter restart, a voxel that is not solid, and the unused code.
        send_item(REQ_BEGIN, pack_item(15, 255, 15, 8'hFF, 1'b1, 1'b1));
        mesh_voxel(0, 0, 1);
        mesh_voxel(1, 0, 0);
        send_item(REQ_UNUSED, pack_item(15, 255, 15, 8'hFF, 1'b1, 1'b1));

        // Opaque chunk boundary on both corners.
        wait_idle();
        write_edge(1'b0);
        mesh_voxel(0, 0, 0);
        mesh_voxel(15, 255, 15);

        // Random phases under changing edge settings.
        wait_idle();
        write_edge(1'b1);
        run_random(PHASE_ITEMS, 1'b0);
        wait_idle();
        write_edge(1'b0);
        run_random(PHASE_ITEMS, 1'b0);
        wait_idle();
        write_edge(1'($urandom_range(0, 1)));
        run_random(PHASE_ITEMS, 1'b0);
        wait_idle();
        write_edge(1'b1);
        run_random(PHASE_ITEMS, 1'b1);
        wait_idle();

        if (sb.errors == 0 && sb.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
